/* rtl/rcc_pkg.sv */
// Shared types, codes and constants of the robot avoidance and command controller.
`default_nettype none
package rcc_pkg;

	// Distance reading width and compare width against the safe threshold
	localparam int DIST_W = 16;
	localparam int SAFE_W = 12;
	localparam int CMP_W  = (DIST_W > SAFE_W) ? DIST_W : SAFE_W;

	// Decoded-word queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Configuration port
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	localparam logic [2:0] REG_SAFE    = 3'd0;
	localparam logic [2:0] REG_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_SETTLE  = 3'd2;
	localparam logic [2:0] REG_BRAKE   = 3'd3;
	localparam logic [2:0] REG_REVERSE = 3'd4;
	localparam logic [2:0] REG_PAUSE   = 3'd5;
	localparam logic [2:0] REG_TURN    = 3'd6;

	// Reset values of the configuration registers
	localparam logic [11:0] SAFE_RST    = 12'd60;
	localparam logic [7:0]  TIMEOUT_RST = 8'd100;
	localparam logic [5:0]  SETTLE_RST  = 6'd10;
	localparam logic [5:0]  BRAKE_RST   = 6'd17;
	localparam logic [5:0]  REVERSE_RST = 6'd17;
	localparam logic [5:0]  PAUSE_RST   = 6'd33;
	localparam logic [5:0]  TURN_RST    = 6'd33;

	// Host command codes
	typedef enum logic [3:0] {
		CMD_F   = 4'd0,
		CMD_B   = 4'd1,
		CMD_L   = 4'd2,
		CMD_R   = 4'd3,
		CMD_SL  = 4'd4,
		CMD_SR  = 4'd5,
		CMD_S   = 4'd6,
		CMD_G   = 4'd7,
		CMD_D   = 4'd8,
		CMD_A   = 4'd9,
		CMD_M   = 4'd10,
		CMD_H   = 4'd11,
		CMD_UNK = 4'd12
	} rcc_cmd_t;

	// Reply kinds
	localparam logic [2:0] RPL_NONE   = 3'd0;
	localparam logic [2:0] RPL_MOTION = 3'd1;
	localparam logic [2:0] RPL_SERVO  = 3'd2;
	localparam logic [2:0] RPL_DIST   = 3'd3;
	localparam logic [2:0] RPL_AUTO   = 3'd4;
	localparam logic [2:0] RPL_MANUAL = 3'd5;
	localparam logic [2:0] RPL_HELP   = 3'd6;
	localparam logic [2:0] RPL_UNK    = 3'd7;

	// Avoidance events
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_OBSTACLE = 3'd1;
	localparam logic [2:0] EV_BACK     = 3'd2;
	localparam logic [2:0] EV_SPIN     = 3'd3;
	localparam logic [2:0] EV_LEFT     = 3'd4;
	localparam logic [2:0] EV_RIGHT    = 3'd5;
	localparam logic [2:0] EV_RESUME   = 3'd6;
	localparam logic [2:0] EV_TIMEOUT  = 3'd7;

	// Speeds and angles
	localparam logic [6:0]        SPEED_MAX  = 7'd100;
	localparam logic signed [15:0] SPEED_LIM = 16'sd100;
	localparam logic signed [15:0] ANGLE_LIM = 16'sd180;
	localparam logic [7:0]        SERVO_FWD  = 8'd90;
	localparam logic [7:0]        SERVO_SIDE = 8'd5;
	localparam logic signed [7:0] CRUISE_POS = 8'sd50;
	localparam logic signed [7:0] CRUISE_NEG = -8'sd50;
	localparam logic signed [7:0] REV_POS    = 8'sd40;
	localparam logic signed [7:0] REV_NEG    = -8'sd40;
	localparam logic signed [7:0] SPIN_FAST  = 8'sd60;
	localparam logic signed [7:0] WHEEL_STOP = 8'sd0;

	// Avoidance phases
	typedef enum logic [5:0] {
		PH_SCAN    = 6'b000001,
		PH_FORWARD = 6'b000010,
		PH_STOP    = 6'b000100,
		PH_BACK    = 6'b001000,
		PH_SCANLR  = 6'b010000,
		PH_TURN    = 6'b100000
	} rcc_phase_t;

	// Input word
	typedef struct packed {
		logic        has_command;
		logic [3:0]  command_code;
		logic signed [15:0] argument;
		logic        argument_valid;
		logic [15:0] front_distance;
		logic [15:0] left_distance;
		logic [15:0] right_distance;
		logic [15:0] probe_distance;
	} rcc_in_t;

	// Result word
	typedef struct packed {
		logic signed [7:0] left_wheel;
		logic signed [7:0] right_wheel;
		logic [7:0]  servo_angle;
		logic        control_mode;
		logic [2:0]  reply_kind;
		logic [15:0] reply_value;
		logic [2:0]  avoid_event;
	} rcc_out_t;

	// Decoded word handed from front to back
	typedef struct packed {
		logic              go_manual;
		logic              go_auto;
		logic              wheel_we;
		logic signed [7:0] wheel_l;
		logic signed [7:0] wheel_r;
		logic              servo_we;
		logic [7:0]        servo;
		logic [2:0]        reply_kind;
		logic [15:0]       reply_value;
		logic              front_block;
		logic              sides_block;
		logic              left_wider;
	} rcc_op_t;

	// Hold and timeout settings used by the back end
	typedef struct packed {
		logic [7:0] timeout_ticks;
		logic [5:0] settle_ticks;
		logic [5:0] brake_ticks;
		logic [5:0] reverse_ticks;
		logic [5:0] pause_ticks;
		logic [5:0] turn_ticks;
	} rcc_cfg_t;

endpackage
`default_nettype wire

/* rtl/rcc_front.sv */
// Front end: decodes the host command and classifies the distance readings.
`default_nettype none
module rcc_front import rcc_pkg::*; (
	input  rcc_in_t     item,
	input  logic [11:0] safe_distance,
	output rcc_op_t     op
);

	logic [6:0]        spd;
	logic [6:0]        spd_inv;
	logic [7:0]        angle;
	logic [7:0]        spd_p;
	logic [7:0]        spd_n;
	logic [7:0]        inv_p;
	logic [7:0]        inv_n;
	logic [DIST_W-1:0] d_front;
	logic [DIST_W-1:0] d_left;
	logic [DIST_W-1:0] d_right;
	logic [CMP_W-1:0]  safe_x;

	// Clamp the argument to speed and angle ranges
	always_comb begin
		if (item.argument < 16'sd0) begin
			spd   = '0;
			angle = '0;
		end else begin
			spd   = (item.argument > SPEED_LIM) ? SPEED_MAX : item.argument[6:0];
			angle = (item.argument > ANGLE_LIM) ? ANGLE_LIM[7:0] : item.argument[7:0];
		end
		spd_inv = SPEED_MAX - spd;
		spd_p   = {1'b0, spd};
		spd_n   = 8'd0 - spd_p;
		inv_p   = {1'b0, spd_inv};
		inv_n   = 8'd0 - inv_p;
	end

	// Classify the readings against the threshold
	assign d_front = item.front_distance[DIST_W-1:0];
	assign d_left  = item.left_distance[DIST_W-1:0];
	assign d_right = item.right_distance[DIST_W-1:0];
	assign safe_x  = CMP_W'(safe_distance);

	// Decode the command into state updates and a reply
	always_comb begin
		op             = '0;
		op.front_block = (d_front != '0) && (CMP_W'(d_front) < safe_x);
		op.sides_block = (CMP_W'(d_left) < safe_x) && (CMP_W'(d_right) < safe_x);
		op.left_wider  = d_left > d_right;
		op.reply_kind  = RPL_NONE;
		if (item.has_command) begin
			if (item.command_code inside {[CMD_F:CMD_S], CMD_M})
				op.go_manual = 1'b1;
			case (item.command_code)
				CMD_F, CMD_B, CMD_L, CMD_R, CMD_SL, CMD_SR: begin
					if (item.argument_valid) begin
						op.wheel_we    = 1'b1;
						op.reply_kind  = RPL_MOTION;
						op.reply_value = 16'(spd);
						case (item.command_code)
							CMD_F: begin
								op.wheel_l = spd_n;
								op.wheel_r = spd_p;
							end
							CMD_B: begin
								op.wheel_l     = inv_p;
								op.wheel_r     = inv_n;
								op.reply_value = 16'(spd_inv);
							end
							CMD_L: begin
								op.wheel_l = WHEEL_STOP;
								op.wheel_r = spd_p;
							end
							CMD_R: begin
								op.wheel_l = spd_n;
								op.wheel_r = WHEEL_STOP;
							end
							CMD_SL: begin
								op.wheel_l = spd_p;
								op.wheel_r = inv_p;
							end
							default: begin
								op.wheel_l = inv_n;
								op.wheel_r = spd_n;
							end
						endcase
					end
				end
				CMD_S: begin
					op.wheel_we   = 1'b1;
					op.wheel_l    = WHEEL_STOP;
					op.wheel_r    = WHEEL_STOP;
					op.reply_kind = RPL_MOTION;
				end
				CMD_G: begin
					if (item.argument_valid) begin
						op.servo_we    = 1'b1;
						op.servo       = angle;
						op.reply_kind  = RPL_SERVO;
						op.reply_value = 16'(angle);
					end
				end
				CMD_D: begin
					op.reply_kind  = RPL_DIST;
					op.reply_value = 16'(item.probe_distance[DIST_W-1:0]);
				end
				CMD_A: begin
					op.go_auto    = 1'b1;
					op.reply_kind = RPL_AUTO;
				end
				CMD_M:   op.reply_kind = RPL_MANUAL;
				CMD_H:   op.reply_kind = RPL_HELP;
				default: op.reply_kind = RPL_UNK;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/rcc_queue.sv */
// Short queue of decoded words between the front and back ends.
`default_nettype none
module rcc_queue import rcc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  rcc_op_t wdata,
	input  logic    rd,
	output rcc_op_t rdata,
	output logic    full,
	output logic    empty
);

	rcc_op_t           slot_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   count_q;
	logic              wr_en;
	logic              rd_en;

	assign full  = count_q == (QPTR_W + 1)'(QDEPTH);
	assign empty = count_q == '0;
	assign wr_en = wr && !full;
	assign rd_en = rd && !empty;
	assign rdata = slot_q[rp_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= wp_q + 1'b1;
			if (rd_en)
				rp_q <= rp_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (wr_en)
			slot_q[wp_q] <= wdata;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W + 1)'(QDEPTH))
		else $error("queue fill count beyond depth");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill count did not grow on write");

endmodule
`default_nettype wire

/* rtl/rcc_back.sv */
// Back end: mode, timeout and avoidance state, plus the result buffer.
`default_nettype none
module rcc_back import rcc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rcc_cfg_t cfg,
	input  rcc_op_t  op,
	input  logic     op_valid,
	output logic     op_take,
	input  logic     pop,
	output logic     empty,
	output rcc_out_t result
);

	logic              mode_q, mode_n;
	rcc_phase_t        phase_q, phase_n;
	logic [5:0]        hold_q, hold_n;
	logic [7:0]        idle_q, idle_n;
	logic signed [7:0] wl_q, wl_n;
	logic signed [7:0] wr_q, wr_n;
	logic [7:0]        servo_q, servo_n;
	logic [2:0]        ev;
	rcc_out_t          res_n;

	rcc_out_t          res_q [2];
	logic              owp_q;
	logic              orp_q;
	logic [1:0]        ocnt_q;
	logic              pop_en;

	assign empty   = ocnt_q == 2'd0;
	assign pop_en  = pop && !empty;
	assign op_take = op_valid && (ocnt_q != 2'd2 || pop_en);
	assign result  = res_q[orp_q];

	// Apply the command, then the timeout, then one avoidance step
	always_comb begin
		mode_n  = mode_q;
		phase_n = phase_q;
		hold_n  = hold_q;
		idle_n  = idle_q;
		wl_n    = wl_q;
		wr_n    = wr_q;
		servo_n = servo_q;
		ev      = EV_NONE;
		if (op.go_manual) begin
			mode_n = 1'b1;
			idle_n = '0;
		end
		if (op.wheel_we) begin
			wl_n = op.wheel_l;
			wr_n = op.wheel_r;
		end
		if (op.servo_we)
			servo_n = op.servo;
		if (op.go_auto)
			mode_n = 1'b0;
		if (mode_n) begin
			if (idle_n >= cfg.timeout_ticks) begin
				mode_n  = 1'b0;
				phase_n = PH_SCAN;
				hold_n  = '0;
				ev      = EV_TIMEOUT;
			end else begin
				idle_n = idle_n + 8'd1;
			end
		end
		if (!mode_n) begin
			if (hold_n != '0) begin
				hold_n = hold_n - 6'd1;
			end else begin
				case (phase_n)
					PH_SCAN: begin
						servo_n = SERVO_FWD;
						hold_n  = cfg.settle_ticks;
						phase_n = PH_FORWARD;
					end
					PH_FORWARD: begin
						servo_n = SERVO_FWD;
						if (op.front_block) begin
							wl_n    = WHEEL_STOP;
							wr_n    = WHEEL_STOP;
							hold_n  = cfg.brake_ticks;
							phase_n = PH_STOP;
							ev      = EV_OBSTACLE;
						end else begin
							wl_n    = CRUISE_NEG;
							wr_n    = CRUISE_POS;
							phase_n = PH_SCAN;
						end
					end
					PH_STOP: begin
						wl_n    = REV_POS;
						wr_n    = REV_NEG;
						hold_n  = cfg.reverse_ticks;
						phase_n = PH_BACK;
						ev      = EV_BACK;
					end
					PH_BACK: begin
						wl_n    = WHEEL_STOP;
						wr_n    = WHEEL_STOP;
						hold_n  = cfg.pause_ticks;
						phase_n = PH_SCANLR;
					end
					PH_SCANLR: begin
						servo_n = SERVO_SIDE;
						if (op.sides_block) begin
							wl_n = SPIN_FAST;
							wr_n = REV_POS;
							ev   = EV_SPIN;
						end else if (op.left_wider) begin
							wl_n = WHEEL_STOP;
							wr_n = CRUISE_POS;
							ev   = EV_LEFT;
						end else begin
							wl_n = CRUISE_NEG;
							wr_n = WHEEL_STOP;
							ev   = EV_RIGHT;
						end
						hold_n  = cfg.turn_ticks;
						phase_n = PH_TURN;
					end
					PH_TURN: begin
						phase_n = PH_SCAN;
						ev      = EV_RESUME;
					end
					default: phase_n = PH_SCAN;
				endcase
			end
		end
		res_n.left_wheel   = wl_n;
		res_n.right_wheel  = wr_n;
		res_n.servo_angle  = servo_n;
		res_n.control_mode = mode_n;
		res_n.reply_kind   = op.reply_kind;
		res_n.reply_value  = op.reply_value;
		res_n.avoid_event  = ev;
	end

	// Commit the state on each word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			phase_q <= PH_SCAN;
			hold_q  <= '0;
			idle_q  <= '0;
			wl_q    <= WHEEL_STOP;
			wr_q    <= WHEEL_STOP;
			servo_q <= SERVO_FWD;
		end else if (op_take) begin
			mode_q  <= mode_n;
			phase_q <= phase_n;
			hold_q  <= hold_n;
			idle_q  <= idle_n;
			wl_q    <= wl_n;
			wr_q    <= wr_n;
			servo_q <= servo_n;
		end
	end

	// Advance the result buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (op_take)
				owp_q <= !owp_q;
			if (pop_en)
				orp_q <= !orp_q;
			if (op_take && !pop_en)
				ocnt_q <= ocnt_q + 2'd1;
			else if (pop_en && !op_take)
				ocnt_q <= ocnt_q - 2'd1;
		end
	end

	// Hold the finished result words
	always_ff @(posedge clk) begin
		if (op_take)
			res_q[owp_q] <= res_n;
	end

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= 2'd2)
		else $error("result buffer overfilled");

	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |=> !empty)
		else $error("taken word left no result");

	a_timeout_auto: assert property (@(posedge clk) disable iff (!arst_n)
		(op_take && ev == EV_TIMEOUT) |=> !mode_q)
		else $error("timeout left manual mode set");

endmodule
`default_nettype wire

/* rtl/robot_avoid_and_command_controller_unit.sv */
// Top level: configuration registers and the front, queue and back ends.
//
//  channel   direction  handshake            payload
//  input     in         push / full          item   (rcc_in_t)
//  result    out        pop / empty          result (rcc_out_t)
//  config    in/out     APB psel/penable     paddr, pwdata, prdata
//
// One word per cycle sustained while results are popped. A pushed word
// is decoded into the four-entry queue; a single back-end step then
// updates mode, timeout and avoidance state and buffers the result.
// full rises when four decoded words wait; a two-entry result buffer lets
// the back end keep taking words while the oldest result is not popped.
// Reset clears the queues and loads all state and registers at once.
`default_nettype none
module robot_avoid_and_command_controller_unit import rcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  rcc_in_t           item,
	output logic              empty,
	input  logic              pop,
	output rcc_out_t          result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	logic [11:0] safe_q;
	rcc_cfg_t    cfg_q;
	logic [2:0]  reg_idx;
	logic        cfg_we;
	rcc_op_t     op_dec;
	rcc_op_t     op_q;
	logic        q_empty;
	logic        op_take;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_AW-1:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_q              <= SAFE_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.settle_ticks  <= SETTLE_RST;
			cfg_q.brake_ticks   <= BRAKE_RST;
			cfg_q.reverse_ticks <= REVERSE_RST;
			cfg_q.pause_ticks   <= PAUSE_RST;
			cfg_q.turn_ticks    <= TURN_RST;
		end else if (cfg_we) begin
			case (reg_idx)
				REG_SAFE:    safe_q              <= pwdata[11:0];
				REG_TIMEOUT: cfg_q.timeout_ticks <= pwdata[7:0];
				REG_SETTLE:  cfg_q.settle_ticks  <= pwdata[5:0];
				REG_BRAKE:   cfg_q.brake_ticks   <= pwdata[5:0];
				REG_REVERSE: cfg_q.reverse_ticks <= pwdata[5:0];
				REG_PAUSE:   cfg_q.pause_ticks   <= pwdata[5:0];
				REG_TURN:    cfg_q.turn_ticks    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (reg_idx)
			REG_SAFE:    prdata = CFG_DW'(safe_q);
			REG_TIMEOUT: prdata = CFG_DW'(cfg_q.timeout_ticks);
			REG_SETTLE:  prdata = CFG_DW'(cfg_q.settle_ticks);
			REG_BRAKE:   prdata = CFG_DW'(cfg_q.brake_ticks);
			REG_REVERSE: prdata = CFG_DW'(cfg_q.reverse_ticks);
			REG_PAUSE:   prdata = CFG_DW'(cfg_q.pause_ticks);
			REG_TURN:    prdata = CFG_DW'(cfg_q.turn_ticks);
			default:     prdata = '0;
		endcase
	end

	rcc_front u_front (
		.item          (item),
		.safe_distance (safe_q),
		.op            (op_dec)
	);

	rcc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (op_dec),
		.rd     (op_take),
		.rdata  (op_q),
		.full   (full),
		.empty  (q_empty)
	);

	rcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op       (op_q),
		.op_valid (!q_empty),
		.op_take  (op_take),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule
`default_nettype wire

/* tb/tb_robot_avoid_and_command_controller_unit.sv */
// Self-checking testbench of the robot avoidance and command controller unit.
module tb_robot_avoid_and_command_controller_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rcc_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int ROUND_ITEMS     = 200;
	localparam int ROUND_COUNT     = 8;
	localparam int TAIL_CYCLES     = 10;
	localparam int REPORT_LIMIT    = 10;
	localparam int TIMEOUT_W       = 8;
	localparam int HOLD_W          = 6;
	// highest command code, beyond the defined set
	localparam logic [3:0] CODE_LAST = 4'hF;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                push    = 1'b0;
	rcc_in_t             item    = '0;
	logic                full;
	logic                empty;
	logic                pop     = 1'b0;
	rcc_out_t            result;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [CFG_AW-1:0]   paddr   = '0;
	logic [CFG_DW-1:0]   pwdata  = '0;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;

	// Register copies used for prediction
	logic [11:0] safe_mm     = SAFE_RST;
	logic [7:0]  timeout_lim = TIMEOUT_RST;
	logic [5:0]  settle_len  = SETTLE_RST;
	logic [5:0]  brake_len   = BRAKE_RST;
	logic [5:0]  reverse_len = REVERSE_RST;
	logic [5:0]  pause_len   = PAUSE_RST;
	logic [5:0]  turn_len    = TURN_RST;

	// Controller state used for prediction
	bit                manual_mode = 1'b0;
	rcc_phase_t        phase       = PH_SCAN;
	logic [5:0]        hold_left   = '0;
	logic [7:0]        idle_ticks  = '0;
	logic signed [7:0] left_spd    = '0;
	logic signed [7:0] right_spd   = '0;
	logic [7:0]        servo_deg   = SERVO_FWD;

	rcc_out_t awaited_results[$];
	int fail_cnt     = 0;
	int tx_idle_pct  = 23;
	int rx_idle_pct  = 80;
	int hold_req     = 0;
	int hold_seen    = 0;
	int hold_cnt     = 0;
	int stall_cycles = 0;

	robot_avoid_and_command_controller_unit u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int clamp_arg(logic signed [15:0] a, int hi);
		int v;
		v = a;
		if (v < 0) v = 0;
		if (v > hi) v = hi;
		return v;
	endfunction

	function automatic void set_wheels(int l, int r);
		left_spd  = 8'(l);
		right_spd = 8'(r);
	endfunction

	// Advance the avoidance sequence by one tick, return its event
	function automatic logic [2:0] advance_avoidance(rcc_in_t w);
		logic [2:0] ev;
		ev = EV_NONE;
		if (hold_left != 0) begin
			hold_left--;
			return EV_NONE;
		end
		case (phase)
		PH_SCAN: begin
			servo_deg = SERVO_FWD;
			hold_left = settle_len;
			phase = PH_FORWARD;
		end
		PH_FORWARD: begin
			servo_deg = SERVO_FWD;
			// zero front reading is no echo, so the way counts as clear
			if (w.front_distance != 0 && w.front_distance < safe_mm) begin
				set_wheels(WHEEL_STOP, WHEEL_STOP);
				hold_left = brake_len;
				phase = PH_STOP;
				ev = EV_OBSTACLE;
			end else begin
				set_wheels(CRUISE_NEG, CRUISE_POS);
				phase = PH_SCAN;
			end
		end
		PH_STOP: begin
			set_wheels(REV_POS, REV_NEG);
			hold_left = reverse_len;
			phase = PH_BACK;
			ev = EV_BACK;
		end
		PH_BACK: begin
			set_wheels(WHEEL_STOP, WHEEL_STOP);
			hold_left = pause_len;
			phase = PH_SCANLR;
		end
		PH_SCANLR: begin
			servo_deg = SERVO_SIDE;
			if (w.left_distance < safe_mm && w.right_distance < safe_mm) begin
				set_wheels(SPIN_FAST, REV_POS);
				ev = EV_SPIN;
			end else if (w.left_distance > w.right_distance) begin
				set_wheels(WHEEL_STOP, CRUISE_POS);
				ev = EV_LEFT;
			end else begin
				set_wheels(CRUISE_NEG, WHEEL_STOP);
				ev = EV_RIGHT;
			end
			hold_left = turn_len;
			phase = PH_TURN;
		end
		PH_TURN: begin
			phase = PH_SCAN;
			ev = EV_RESUME;
		end
		default: phase = PH_SCAN;
		endcase
		return ev;
	endfunction

	// Work out the result word of one control tick and update state
	function automatic rcc_out_t next_tick_result(rcc_in_t w);
		rcc_out_t r;
		int s;
		logic [2:0] ev;
		logic [2:0] reply;
		logic [15:0] rval;
		logic [2:0] step_ev;
		reply = RPL_NONE;
		rval = '0;
		ev = EV_NONE;
		if (w.has_command) begin
			if (w.command_code <= CMD_S) begin
				manual_mode = 1'b1;
				idle_ticks = '0;
			end
			if (w.command_code <= CMD_SR && w.argument_valid) begin
				s = clamp_arg(w.argument, int'(SPEED_LIM));
				case (w.command_code)
				CMD_F: set_wheels(-s, s);
				CMD_B: begin
					s = int'(SPEED_MAX) - s;
					set_wheels(s, -s);
				end
				CMD_L: set_wheels(0, s);
				CMD_R: set_wheels(-s, 0);
				CMD_SL: set_wheels(s, int'(SPEED_MAX) - s);
				default: set_wheels(-(int'(SPEED_MAX) - s), -s);
				endcase
				reply = RPL_MOTION;
				rval = 16'(s);
			end else if (w.command_code == CMD_S) begin
				set_wheels(WHEEL_STOP, WHEEL_STOP);
				reply = RPL_MOTION;
			end else if (w.command_code == CMD_G) begin
				if (w.argument_valid) begin
					servo_deg = 8'(clamp_arg(w.argument, int'(ANGLE_LIM)));
					reply = RPL_SERVO;
					rval = 16'(servo_deg);
				end
			end else if (w.command_code == CMD_D) begin
				reply = RPL_DIST;
				rval = w.probe_distance;
			end else if (w.command_code == CMD_A) begin
				manual_mode = 1'b0;
				reply = RPL_AUTO;
			end else if (w.command_code == CMD_M) begin
				manual_mode = 1'b1;
				idle_ticks = '0;
				reply = RPL_MANUAL;
			end else if (w.command_code == CMD_H) begin
				reply = RPL_HELP;
			end else if (w.command_code >= CMD_UNK) begin
				reply = RPL_UNK;
			end
		end
		// Drop back to automatic once manual mode sat idle long enough
		if (manual_mode) begin
			if (idle_ticks >= timeout_lim) begin
				manual_mode = 1'b0;
				phase = PH_SCAN;
				hold_left = '0;
				ev = EV_TIMEOUT;
			end else begin
				idle_ticks = idle_ticks + 8'd1;
			end
		end
		if (!manual_mode) begin
			step_ev = advance_avoidance(w);
			if (step_ev != EV_NONE) ev = step_ev;
		end
		r.left_wheel   = left_spd;
		r.right_wheel  = right_spd;
		r.servo_angle  = servo_deg;
		r.control_mode = manual_mode;
		r.reply_kind   = reply;
		r.reply_value  = rval;
		r.avoid_event  = ev;
		return r;
	endfunction

	function automatic logic [15:0] pick_distance();
		int v;
		case ($urandom_range(3))
		0: return '0;
		1: begin
			// land around the threshold
			v = int'(safe_mm) + int'($urandom_range(8)) - 4;
			if (v < 0) v = 0;
			return 16'(v);
		end
		2: return 16'($urandom_range(400));
		default: return 16'($urandom());
		endcase
	endfunction

	function automatic rcc_in_t random_word();
		rcc_in_t w;
		logic [95:0] bits;
		bits = {$urandom(), $urandom(), $urandom()};
		w = bits[$bits(rcc_in_t)-1:0];
		w.has_command = ($urandom_range(99) < 12);
		w.argument_valid = ($urandom_range(99) < 80);
		case ($urandom_range(3))
		0: w.argument = 16'($urandom_range(120)) - 16'sd10;
		1: w.argument = 16'($urandom_range(200));
		default: ;
		endcase
		w.front_distance = pick_distance();
		w.left_distance = pick_distance();
		w.right_distance = pick_distance();
		if ($urandom_range(9) == 0) w.right_distance = w.left_distance;
		return w;
	endfunction

	function automatic rcc_in_t cmd_word(logic [3:0] code, logic signed [15:0] arg, bit valid);
		rcc_in_t w;
		w = random_word();
		w.has_command = 1'b1;
		w.command_code = code;
		w.argument = arg;
		w.argument_valid = valid;
		return w;
	endfunction

	function automatic rcc_in_t dist_word(logic [15:0] f, logic [15:0] l, logic [15:0] r);
		rcc_in_t w;
		w = random_word();
		w.has_command = 1'b0;
		w.front_distance = f;
		w.left_distance = l;
		w.right_distance = r;
		return w;
	endfunction

	// Offer one word, wait for it to be taken, queue its result
	task automatic send_word(rcc_in_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		awaited_results.push_back(next_tick_result(w));
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	// Setup and access phase; back-to-back writes keep psel high
	task automatic write_reg(logic [2:0] idx, int unsigned v, int w);
		logic [CFG_DW-1:0] data;
		data = (CFG_DW'($urandom()) << w) | CFG_DW'(v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
		REG_SAFE: safe_mm = data[SAFE_W-1:0];
		REG_TIMEOUT: timeout_lim = data[TIMEOUT_W-1:0];
		REG_SETTLE: settle_len = data[HOLD_W-1:0];
		REG_BRAKE: brake_len = data[HOLD_W-1:0];
		REG_REVERSE: reverse_len = data[HOLD_W-1:0];
		REG_PAUSE: pause_len = data[HOLD_W-1:0];
		REG_TURN: turn_len = data[HOLD_W-1:0];
		default: ;
		endcase
	endtask

	task automatic apply_settings(int unsigned safe, int unsigned tmo, int unsigned settle,
			int unsigned brake, int unsigned rev, int unsigned pause, int unsigned turn);
		drain_results();
		write_reg(REG_SAFE, safe, SAFE_W);
		write_reg(REG_TIMEOUT, tmo, TIMEOUT_W);
		write_reg(REG_SETTLE, settle, HOLD_W);
		write_reg(REG_BRAKE, brake, HOLD_W);
		write_reg(REG_REVERSE, rev, HOLD_W);
		write_reg(REG_PAUSE, pause, HOLD_W);
		write_reg(REG_TURN, turn, HOLD_W);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Every command code but CMD_M, argument extremes, missing arguments
	task automatic test_commands();
		rcc_in_t w;
		send_word(cmd_word(CMD_F, 16'sh8000, 1'b1));
		send_word(cmd_word(CMD_F, 16'sh7FFF, 1'b1));
		send_word(cmd_word(CMD_B, 16'sd0, 1'b1));
		send_word(cmd_word(CMD_L, 16'sd100, 1'b1));
		send_word(cmd_word(CMD_R, 16'sd37, 1'b1));
		send_word(cmd_word(CMD_SL, 16'sd101, 1'b1));
		send_word(cmd_word(CMD_SR, 16'sd25, 1'b1));
		send_word(cmd_word(CMD_F, 16'sd80, 1'b0));
		send_word(cmd_word(CMD_S, 16'sh7FFF, 1'b0));
		send_word(cmd_word(CMD_G, -16'sd1, 1'b1));
		send_word(cmd_word(CMD_G, 16'sd181, 1'b1));
		send_word(cmd_word(CMD_G, 16'sd45, 1'b0));
		w = cmd_word(CMD_D, 16'sd0, 1'b1);
		w.probe_distance = '1;
		send_word(w);
		send_word(cmd_word(CMD_H, 16'sd0, 1'b0));
		send_word(cmd_word(CMD_UNK, 16'sd0, 1'b0));
		send_word(cmd_word(CODE_LAST, 16'sd0, 1'b1));
		send_word(cmd_word(CMD_A, 16'sd0, 1'b0));
		// command fields without the command flag are ignored
		w = cmd_word(CMD_M, 16'sd50, 1'b1);
		w.has_command = 1'b0;
		send_word(w);
	endtask

	// Walk the avoidance sequence from a timeout with zero holds
	task automatic test_avoid_sequence();
		apply_settings(12'hFFF, 1, 0, 0, 0, 0, 0);
		send_word(cmd_word(CMD_M, 16'sd0, 1'b0));
		send_word(dist_word(16'd4094, 16'd4094, 16'd4094));
		send_word(dist_word(16'd4094, 16'd4094, 16'd4094));
		send_word(dist_word(16'd4094, 16'd4094, 16'd4094));
		send_word(dist_word(16'd4094, 16'd4094, 16'd4094));
		send_word(dist_word(16'd4094, 16'd4094, 16'd4094));
		send_word(dist_word(16'd4094, 16'd4094, 16'd4094));
		send_word(dist_word(16'd0, 16'd0, 16'd0));
		send_word(dist_word(16'd0, 16'd0, 16'd0));
	endtask

	task automatic test_random_rounds();
		for (int rnd = 0; rnd < ROUND_COUNT; rnd++) begin
			tx_idle_pct = (rnd < 3) ? 23 : ((rnd < 6) ? 80 : 0);
			rx_idle_pct = (rnd < 3) ? 80 : ((rnd < 6) ? 23 : 0);
			case (rnd)
			0: apply_settings(0, 1, 0, 0, 0, 0, 0);
			1: apply_settings(12'hFFF, 8'hFF, 63, 63, 63, 63, 63);
			3: apply_settings(SAFE_RST, TIMEOUT_RST, SETTLE_RST, BRAKE_RST, REVERSE_RST,
					PAUSE_RST, TURN_RST);
			default: apply_settings($urandom_range(400, 20), $urandom_range(12, 1),
					$urandom_range(3), $urandom_range(3), $urandom_range(3),
					$urandom_range(3), $urandom_range(3));
			endcase
			repeat (ROUND_ITEMS) send_word(random_word());
		end
	endtask

	// Keep offering words while the result side holds off
	task automatic test_back_pressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req++;
		repeat (40) send_word(random_word());
	endtask

	// Check each popped word, then pick the next pop
	always @(posedge clk) begin
		rcc_out_t want;
		if (pop && !empty) begin
			if (awaited_results.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= REPORT_LIMIT)
					$display("unexpected result word: lw=%0d rw=%0d servo=%0d mode=%0b",
						result.left_wheel, result.right_wheel, result.servo_angle,
						result.control_mode);
			end else begin
				want = awaited_results.pop_front();
				if (result.left_wheel !== want.left_wheel ||
						result.right_wheel !== want.right_wheel ||
						result.servo_angle !== want.servo_angle ||
						result.control_mode !== want.control_mode ||
						result.reply_kind !== want.reply_kind ||
						result.reply_value !== want.reply_value ||
						result.avoid_event !== want.avoid_event) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_LIMIT) begin
						$display("mismatch exp lw=%0d rw=%0d servo=%0d mode=%0b reply=%0d/%0d ev=%0d",
							want.left_wheel, want.right_wheel, want.servo_angle,
							want.control_mode, want.reply_kind, want.reply_value,
							want.avoid_event);
						$display("         got lw=%0d rw=%0d servo=%0d mode=%0b reply=%0d/%0d ev=%0d",
							result.left_wheel, result.right_wheel, result.servo_angle,
							result.control_mode, result.reply_kind, result.reply_value,
							result.avoid_event);
					end
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_cnt = HOLD_OFF_CYCLES;
		end
		if (hold_cnt != 0) begin
			hold_cnt--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands();
		test_avoid_sequence();
		test_random_rounds();
		test_back_pressure();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) fail_cnt++;
		if (fail_cnt == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/rcc_pkg.sv
rtl/rcc_front.sv
rtl/rcc_queue.sv
rtl/rcc_back.sv
rtl/robot_avoid_and_command_controller_unit.sv
tb/tb_robot_avoid_and_command_controller_unit.sv
